// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bmfse_pkg.sv -----
package bmfse_pkg;

  // Default table sizes
  localparam int DEF_MAX_DIMS   = 16;
  localparam int DEF_MAX_USERS  = 1024;
  localparam int DEF_MAX_VIDEOS = 1024;

  // Field widths
  localparam int MODE_W      = 3;
  localparam int ID_W        = 10;
  localparam int EL_W        = 4;
  localparam int Q_W         = 16;
  localparam int DIMS_CFG_W  = 5;
  localparam int COUNT_CFG_W = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int TOTAL_W     = 63;
  localparam int CNT_W       = 32;
  localparam int MAG_W       = 32;
  localparam int SQ_W        = 64;
  // Widths wide enough to compare ids with table sizes below 2**21 and element indexes with sizes below 2**9
  localparam int ID_EXT_W    = 21;
  localparam int EL_EXT_W    = 9;

  // Register reset values
  localparam logic [DIMS_CFG_W-1:0]  DIMS_RST  = 5'd16;
  localparam logic [COUNT_CFG_W-1:0] COUNT_RST = 11'd1024;

  // Request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_USER_FAC   = 3'd0,
    MODE_VIDEO_FAC  = 3'd1,
    MODE_USER_BIAS  = 3'd2,
    MODE_VIDEO_BIAS = 3'd3,
    MODE_SCORE      = 3'd4,
    MODE_REPORT     = 3'd5
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMS        = 2'd0,
    CFG_USER_COUNT  = 2'd1,
    CFG_VIDEO_COUNT = 2'd2,
    CFG_GLOBAL_BIAS = 2'd3
  } cfg_idx_t;

  // Commands from the request decode and the sequencer to the error/total unit
  typedef struct packed {
    logic calc;
    logic reject;
    logic report;
  } err_cmd_t;

endpackage

// ----- src/biased_mf_squared_error_sum.sv -----
// Biased matrix-factorization squared-error accumulator.
// Input channel (in_valid/in_ready) takes one request: factor or bias writes
// (modes 0-3), scoring of a rating record (mode 4) or a report (mode 5).
// Config channel (cfg_valid/cfg_ready, always ready) sets dims in use,
// user and video counts and the global bias; write it only while idle.
// A scored record makes one read of each factor memory per dimension,
// then passes through a two-stage multiply-accumulate and the error,
// square and total stages. Rejected records are only counted.
// A report shows up on out_valid the cycle after it is accepted and clears
// the totals. While that result waits for out_ready, writes and scores are
// still accepted; a further report is held off until the output frees up.
// Reset (rst_n low, synchronous) clears the totals, the sequencer and the
// registers to their defaults. Table contents are undefined until written;
// no clearing pass runs.
`include "assert_macros.svh"

module biased_mf_squared_error_sum #(
  parameter int MAX_DIMS   = bmfse_pkg::DEF_MAX_DIMS,
  parameter int MAX_USERS  = bmfse_pkg::DEF_MAX_USERS,
  parameter int MAX_VIDEOS = bmfse_pkg::DEF_MAX_VIDEOS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bmfse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bmfse_pkg::Q_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [bmfse_pkg::MODE_W-1:0]          in_mode,
  input  logic [bmfse_pkg::ID_W-1:0]            in_user_id,
  input  logic [bmfse_pkg::ID_W-1:0]            in_video_id,
  input  logic [bmfse_pkg::EL_W-1:0]            in_element_index,
  input  logic signed [bmfse_pkg::Q_W-1:0]      in_write_value,
  input  logic signed [bmfse_pkg::Q_W-1:0]      in_rating,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bmfse_pkg::TOTAL_W-1:0]         out_squared_error_total,
  output logic [bmfse_pkg::CNT_W-1:0]           out_records_scored,
  output logic [bmfse_pkg::CNT_W-1:0]           out_records_rejected
);

  import bmfse_pkg::*;

  localparam int DKW        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DCW        = $clog2(MAX_DIMS + 1);
  localparam int UAW        = $clog2(MAX_USERS);
  localparam int VAW        = $clog2(MAX_VIDEOS);
  localparam int UFAC_DEPTH = MAX_USERS * (2 ** DKW);
  localparam int VFAC_DEPTH = MAX_VIDEOS * (2 ** DKW);
  localparam int DOT_W      = 2 * Q_W + 1 + DKW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ERR   = 5'b01000,
    S_WAIT  = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [DKW-1:0]             k_r;
  logic [UAW-1:0]             urow_r;
  logic [VAW-1:0]             vrow_r;
  logic signed [Q_W-1:0]      rating_r;

  logic [DIMS_CFG_W-1:0]      dims_r;
  logic [COUNT_CFG_W-1:0]     user_count_r;
  logic [COUNT_CFG_W-1:0]     video_count_r;
  logic signed [Q_W-1:0]      global_bias_r;

  logic                       in_acc;
  logic [ID_EXT_W-1:0]        uid_ext;
  logic [ID_EXT_W-1:0]        vid_ext;
  logic [EL_EXT_W-1:0]        el_ext;
  logic                       uid_in_tab;
  logic                       vid_in_tab;
  logic                       el_in_tab;
  logic                       score_ok;
  logic                       score_go;
  logic [DCW-1:0]             dims_eff;
  logic                       last_k;

  logic                       ufac_we;
  logic                       vfac_we;
  logic                       ubias_we;
  logic                       vbias_we;
  logic                       issue;
  logic signed [Q_W-1:0]      ufac_rd;
  logic signed [Q_W-1:0]      vfac_rd;
  logic signed [Q_W-1:0]      ubias_rd;
  logic signed [Q_W-1:0]      vbias_rd;
  logic                       mac_busy;
  logic signed [DOT_W-1:0]    dot;
  logic                       err_busy;
  err_cmd_t                   err_cmd;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r        <= DIMS_RST;
      user_count_r  <= COUNT_RST;
      video_count_r <= COUNT_RST;
      global_bias_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIMS:        dims_r        <= cfg_data[DIMS_CFG_W-1:0];
        CFG_USER_COUNT:  user_count_r  <= cfg_data[COUNT_CFG_W-1:0];
        CFG_VIDEO_COUNT: video_count_r <= cfg_data[COUNT_CFG_W-1:0];
        CFG_GLOBAL_BIAS: global_bias_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request decode and id range checks
  assign in_ready = (state_r == S_IDLE) &&
                    ((in_mode != MODE_REPORT) || !out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;

  assign uid_ext    = ID_EXT_W'(in_user_id);
  assign vid_ext    = ID_EXT_W'(in_video_id);
  assign el_ext     = EL_EXT_W'(in_element_index);
  assign uid_in_tab = uid_ext < ID_EXT_W'(MAX_USERS);
  assign vid_in_tab = vid_ext < ID_EXT_W'(MAX_VIDEOS);
  assign el_in_tab  = el_ext < EL_EXT_W'(MAX_DIMS);
  assign score_ok   = uid_in_tab && vid_in_tab &&
                      (uid_ext < ID_EXT_W'(user_count_r)) &&
                      (vid_ext < ID_EXT_W'(video_count_r));
  assign score_go   = in_acc && (in_mode == MODE_SCORE) && score_ok;

  // Clamp the dimension count to the table width
  always_comb begin
    if (EL_EXT_W'(dims_r) > EL_EXT_W'(MAX_DIMS)) begin
      dims_eff = DCW'(MAX_DIMS);
    end else begin
      dims_eff = DCW'(dims_r);
    end
  end

  assign last_k = (DCW'(k_r) + DCW'(1)) == dims_eff;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (score_go) begin
          state_nxt = (dims_eff == '0) ? S_DRAIN : S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (last_k) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!err_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (score_go) begin
        k_r <= '0;
      end else if (issue) begin
        k_r <= k_r + DKW'(1);
      end
    end
  end

  // Hold the record's rows and rating for the run
  always_ff @(posedge clk) begin
    if (score_go) begin
      urow_r   <= uid_ext[UAW-1:0];
      vrow_r   <= vid_ext[VAW-1:0];
      rating_r <= in_rating;
    end
  end

  // Memory controls
  assign issue    = (state_r == S_ISSUE);
  assign ufac_we  = in_acc && (in_mode == MODE_USER_FAC) && uid_in_tab && el_in_tab;
  assign vfac_we  = in_acc && (in_mode == MODE_VIDEO_FAC) && vid_in_tab && el_in_tab;
  assign ubias_we = in_acc && (in_mode == MODE_USER_BIAS) && uid_in_tab;
  assign vbias_we = in_acc && (in_mode == MODE_VIDEO_BIAS) && vid_in_tab;

  bmfse_ram #(.W(Q_W), .DEPTH(UFAC_DEPTH)) u_ufac (
    .clk   (clk),
    .we    (ufac_we),
    .waddr ({uid_ext[UAW-1:0], el_ext[DKW-1:0]}),
    .wdata (in_write_value),
    .re    (issue),
    .raddr ({urow_r, k_r}),
    .rdata (ufac_rd)
  );

  bmfse_ram #(.W(Q_W), .DEPTH(VFAC_DEPTH)) u_vfac (
    .clk   (clk),
    .we    (vfac_we),
    .waddr ({vid_ext[VAW-1:0], el_ext[DKW-1:0]}),
    .wdata (in_write_value),
    .re    (issue),
    .raddr ({vrow_r, k_r}),
    .rdata (vfac_rd)
  );

  bmfse_ram #(.W(Q_W), .DEPTH(MAX_USERS)) u_ubias (
    .clk   (clk),
    .we    (ubias_we),
    .waddr (uid_ext[UAW-1:0]),
    .wdata (in_write_value),
    .re    (score_go),
    .raddr (uid_ext[UAW-1:0]),
    .rdata (ubias_rd)
  );

  bmfse_ram #(.W(Q_W), .DEPTH(MAX_VIDEOS)) u_vbias (
    .clk   (clk),
    .we    (vbias_we),
    .waddr (vid_ext[VAW-1:0]),
    .wdata (in_write_value),
    .re    (score_go),
    .raddr (vid_ext[VAW-1:0]),
    .rdata (vbias_rd)
  );

  // Dot product over the factor rows
  bmfse_mac #(.DOT_W(DOT_W)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (score_go),
    .issue (issue),
    .a     (ufac_rd),
    .b     (vfac_rd),
    .busy  (mac_busy),
    .dot   (dot)
  );

  // Error, square, totals and report register
  always_comb begin
    err_cmd.calc   = (state_r == S_ERR);
    err_cmd.reject = in_acc && (in_mode == MODE_SCORE) && !score_ok;
    err_cmd.report = in_acc && (in_mode == MODE_REPORT);
  end

  bmfse_err #(.DOT_W(DOT_W)) u_err (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (err_cmd),
    .rating                  (rating_r),
    .user_bias               (ubias_rd),
    .video_bias              (vbias_rd),
    .global_bias             (global_bias_r),
    .dot                     (dot),
    .busy                    (err_busy),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_squared_error_total (out_squared_error_total),
    .out_records_scored      (out_records_scored),
    .out_records_rejected    (out_records_rejected)
  );

  // Checks
  `ASSERT_IMPLIES(a_ready_only_idle, clk, rst_n, in_ready, state_r == S_IDLE, "ready outside idle")
  `ASSERT_NEXT(a_report_shows, clk, rst_n, err_cmd.report, out_valid, "report not presented")
  `ASSERT_IMPLIES(a_mac_quiet_idle, clk, rst_n, state_r == S_IDLE, !(mac_busy | err_busy), "idle busy")
  `ASSERT_IMPLIES(a_k_in_range, clk, rst_n, state_r == S_ISSUE, DCW'(k_r) < dims_eff, "k past dims")

endmodule

// ----- src/bmfse_ram.sv -----
module bmfse_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [W-1:0]               wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [W-1:0]               rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/bmfse_mac.sv -----
module bmfse_mac #(
  parameter int DOT_W = 37
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  logic                                issue,
  input  logic signed [bmfse_pkg::Q_W-1:0]    a,
  input  logic signed [bmfse_pkg::Q_W-1:0]    b,
  output logic                                busy,
  output logic signed [DOT_W-1:0]             dot
);

  import bmfse_pkg::*;

  logic                       vld_d1_r;
  logic                       prod_vld_r;
  logic signed [2*Q_W-1:0]    prod_r;
  logic signed [DOT_W-1:0]    dot_r;

  // Valid flags for the read data and the product, registered behind the issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d1_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      vld_d1_r   <= issue;
      prod_vld_r <= vld_d1_r;
    end
  end

  // Multiply the factor pair read from memory
  always_ff @(posedge clk) begin
    if (vld_d1_r) begin
      prod_r <= a * b;
    end
  end

  // Accumulate products, clear at the start of a record
  always_ff @(posedge clk) begin
    if (clr) begin
      dot_r <= '0;
    end else if (prod_vld_r) begin
      dot_r <= dot_r + DOT_W'(prod_r);
    end
  end

  assign busy = vld_d1_r | prod_vld_r;
  assign dot  = dot_r;

endmodule

// ----- src/bmfse_err.sv -----
module bmfse_err #(
  parameter int DOT_W = 37
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bmfse_pkg::err_cmd_t                   cmd,
  input  logic signed [bmfse_pkg::Q_W-1:0]      rating,
  input  logic signed [bmfse_pkg::Q_W-1:0]      user_bias,
  input  logic signed [bmfse_pkg::Q_W-1:0]      video_bias,
  input  logic signed [bmfse_pkg::Q_W-1:0]      global_bias,
  input  logic signed [DOT_W-1:0]               dot,
  output logic                                  busy,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bmfse_pkg::TOTAL_W-1:0]         out_squared_error_total,
  output logic [bmfse_pkg::CNT_W-1:0]           out_records_scored,
  output logic [bmfse_pkg::CNT_W-1:0]           out_records_rejected
);

  import bmfse_pkg::*;

  localparam int EW   = DOT_W + 1;
  localparam int E12W = EW - 12;
  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

  logic signed [Q_W+1:0]  bias_sum;
  logic signed [EW-1:0]   bias24;
  logic signed [EW-1:0]   err24;
  logic signed [E12W-1:0] err12;
  logic signed [63:0]     err64;
  logic [MAG_W-1:0]       err_sat;
  logic [MAG_W-1:0]       mag_nxt;
  logic [SQ_W-1:0]        sum64;
  logic [TOTAL_W-1:0]     total_nxt;

  logic                   mag_vld_r;
  logic                   sq_vld_r;
  logic [MAG_W-1:0]       mag_r;
  logic [SQ_W-1:0]        sq_r;
  logic [TOTAL_W-1:0]     total_r;
  logic [CNT_W-1:0]       scored_r;
  logic [CNT_W-1:0]       rejected_r;
  logic                   out_valid_r;
  logic [TOTAL_W-1:0]     out_total_r;
  logic [CNT_W-1:0]       out_scored_r;
  logic [CNT_W-1:0]       out_rejected_r;

  // Form the error at Q.24, floor-shift to Q.12, saturate and take magnitude
  always_comb begin
    bias_sum = (Q_W+2)'(rating) - (Q_W+2)'(user_bias) - (Q_W+2)'(video_bias)
             - (Q_W+2)'(global_bias);
    bias24   = EW'(bias_sum) <<< 12;
    err24    = bias24 - EW'(dot);
    err12    = err24[EW-1:12];
    err64    = 64'(err12);
    if (err64 > SAT_HI) begin
      err_sat = 32'h7FFF_FFFF;
    end else if (err64 < SAT_LO) begin
      err_sat = 32'h8000_0000;
    end else begin
      err_sat = err64[MAG_W-1:0];
    end
    mag_nxt = err_sat[MAG_W-1] ? (~err_sat + 32'd1) : err_sat;
  end

  // Saturating add of the square into the total
  always_comb begin
    sum64     = {1'b0, total_r} + sq_r;
    total_nxt = sum64[SQ_W-1] ? '1 : sum64[TOTAL_W-1:0];
  end

  // Advance the error pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_vld_r <= 1'b0;
      sq_vld_r  <= 1'b0;
    end else begin
      mag_vld_r <= cmd.calc;
      sq_vld_r  <= mag_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      mag_r <= mag_nxt;
    end
    if (mag_vld_r) begin
      sq_r <= mag_r * mag_r;
    end
  end

  // Totals: accumulate, count, report and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      scored_r   <= '0;
      rejected_r <= '0;
    end else if (cmd.report) begin
      total_r    <= '0;
      scored_r   <= '0;
      rejected_r <= '0;
    end else begin
      if (sq_vld_r) begin
        total_r <= total_nxt;
        if (scored_r != '1) begin
          scored_r <= scored_r + CNT_W'(1);
        end
      end
      if (cmd.reject && rejected_r != '1) begin
        rejected_r <= rejected_r + CNT_W'(1);
      end
    end
  end

  // Output register, holds the report until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.report) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_total_r    <= total_r;
      out_scored_r   <= scored_r;
      out_rejected_r <= rejected_r;
    end
  end

  assign busy                    = mag_vld_r | sq_vld_r;
  assign out_valid               = out_valid_r;
  assign out_squared_error_total = out_total_r;
  assign out_records_scored      = out_scored_r;
  assign out_records_rejected    = out_rejected_r;

endmodule
